// ----- rtl/core/mmc_pkg.sv -----
package mmc_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int IDX_W           = 10;
  localparam int KC_W            = 11;
  localparam int CMD_W           = 2;
  localparam int ST_W            = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_READY = 3'd4
  } status_t;

endpackage

// ----- rtl/core/mmc_ram.sv -----
module mmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/median_mean_centering.sv -----
// Median, mean and median-centered readback of a series of signed samples.
// Input channel in_*: in_tuser carries the command and the invalid flag,
// in_tdata the sample and the read index. Every accepted transaction gives
// exactly one result transaction on out_*: median, mean, centered sample and
// kept count in out_tdata, status in out_tuser.
// Work done for each command after acceptance, before the result is ready:
//   load:    into an empty store the sample is written directly, else each
//            stored sample greater than the new one is moved up (insertion into the
//            sorted memory, one entry per cycle through its single read port)
//   compute: one median read (odd count) or two (even count) of the sorted
//            memory, then the bit-serial divider for the mean
//   read:    sample memory read, then subtract and saturate
//   clear, dropped load, error cases: the result goes straight to the output stage
// One transaction is in work at a time; the next is taken as soon as the
// block is back in idle, even while the previous result waits in the output
// register. When the receiver stalls, a finished result waits until the
// output register is free. Reset empties the store and clears the median,
// mean and computed state; memory contents are not cleared.
module median_mean_centering #(
  parameter int MAX_SAMPLES = mmc_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + mmc_pkg::IDX_W + 7) / 8) * 8,
  localparam int OUT_W = ((3 * SAMPLE_BITS + mmc_pkg::KC_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,  // sample_value, read_index
  input  logic [2:0]               in_tuser,  // cmd, sample_invalid
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_W-1:0]         out_tdata, // median, mean, centered, kept_count
  output logic [mmc_pkg::ST_W-1:0] out_tuser  // status
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW  = SB + CW;
  localparam int DCW   = $clog2(SUMW + 1);
  localparam int IW    = mmc_pkg::IDX_W;
  localparam int KW    = mmc_pkg::KC_W;
  localparam int PAD_O = OUT_W - 3 * SB - KW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_INS  = 8'b00000010,
    S_INS0 = 8'b00000100,
    S_MED1 = 8'b00001000,
    S_MED2 = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_RDW  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SB-1:0]          x_r, x_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          total_r, total_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [SB-1:0]          med_r, med_nxt;
  logic [SB-1:0]          mean_r, mean_nxt;
  logic                   flag_r, flag_nxt;
  logic [SB-1:0]          a_r, a_nxt;
  logic [SB-1:0]          cen_r, cen_nxt;
  mmc_pkg::status_t       stat_r, stat_nxt;
  logic [SUMW-1:0]        q_r, q_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [DCW-1:0]         cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [mmc_pkg::ST_W-1:0] out_user_r, out_user_nxt;

  logic                   accept;
  mmc_pkg::cmd_t          in_cmd;
  logic                   in_inv;
  logic [SB-1:0]          in_x;
  logic [IW-1:0]          in_idx;
  logic [AW+IW-1:0]       idx_ext;
  logic [CW-1:0]          half, half_m1, total_m1;

  logic          s_we;
  logic [AW-1:0] s_raddr;
  logic [SB-1:0] s_rdata;
  logic          o_we;
  logic [AW-1:0] o_waddr, o_raddr;
  logic [SB-1:0] o_wdata, o_rdata;

  logic [CW:0]     trial;
  logic            qbit;
  logic [SUMW-1:0] q_step, q_fin;
  logic [SB:0]     pair_sum, diff;

  assign in_cmd  = mmc_pkg::cmd_t'(in_tuser[1:0]);
  assign in_inv  = in_tuser[2];
  assign in_x    = in_tdata[SB-1:0];
  assign in_idx  = in_tdata[SB+IW-1:SB];
  assign idx_ext = {{AW{1'b0}}, in_idx};
  assign in_tready = (state_r == S_IDLE);
  assign accept  = in_tvalid && in_tready;

  assign half     = total_r >> 1;
  assign half_m1  = half - CW'(1);
  assign total_m1 = total_r - CW'(1);

  assign trial  = {rem_r, q_r[SUMW-1]};
  assign qbit   = (trial >= {1'b0, total_r});
  assign q_step = {q_r[SUMW-2:0], qbit};
  assign q_fin  = neg_r ? (~q_step + SUMW'(1)) : q_step;

  assign pair_sum = {a_r[SB-1], a_r} + {o_rdata[SB-1], o_rdata};
  assign diff     = {s_rdata[SB-1], s_rdata} - {med_r[SB-1], med_r};

  mmc_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (total_r[AW-1:0]),
    .wdata (in_x),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mmc_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_sorted_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    med_nxt       = med_r;
    mean_nxt      = mean_r;
    flag_nxt      = flag_r;
    a_nxt         = a_r;
    cen_nxt       = cen_r;
    stat_nxt      = stat_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    s_we          = 1'b0;
    s_raddr       = idx_ext[AW-1:0];
    o_we          = 1'b0;
    o_waddr       = pos_r;
    o_wdata       = x_r;
    o_raddr       = total_m1[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt     = in_x;
          cen_nxt   = '0;
          stat_nxt  = mmc_pkg::ST_OK;
          state_nxt = S_DONE;
          unique case (in_cmd)
            mmc_pkg::CMD_LOAD: begin
              if (in_inv) begin
                stat_nxt = mmc_pkg::ST_OK;
              end else if (total_r == CW'(MAX_SAMPLES)) begin
                stat_nxt = mmc_pkg::ST_FULL;
              end else begin
                s_we      = 1'b1;
                total_nxt = total_r + CW'(1);
                sum_nxt   = sum_r + {{(SUMW-SB){in_x[SB-1]}}, in_x};
                flag_nxt  = 1'b0;
                med_nxt   = '0;
                mean_nxt  = '0;
                pos_nxt   = total_r[AW-1:0];
                if (total_r == '0) begin
                  o_we    = 1'b1;
                  o_waddr = '0;
                  o_wdata = in_x;
                end else begin
                  o_raddr   = total_m1[AW-1:0];
                  state_nxt = S_INS;
                end
              end
            end
            mmc_pkg::CMD_COMPUTE: begin
              if (total_r == '0) begin
                stat_nxt = mmc_pkg::ST_EMPTY;
              end else begin
                o_raddr   = total_r[0] ? half[AW-1:0] : half_m1[AW-1:0];
                state_nxt = S_MED1;
              end
            end
            mmc_pkg::CMD_READ: begin
              if (!flag_r) begin
                stat_nxt = mmc_pkg::ST_NOT_READY;
              end else if ({{CW{1'b0}}, in_idx} >= {{IW{1'b0}}, total_r}) begin
                stat_nxt = mmc_pkg::ST_BAD_INDEX;
              end else begin
                s_raddr   = idx_ext[AW-1:0];
                state_nxt = S_RDW;
              end
            end
            mmc_pkg::CMD_CLEAR: begin
              total_nxt = '0;
              sum_nxt   = '0;
              med_nxt   = '0;
              mean_nxt  = '0;
              flag_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        o_we = 1'b1;
        if ($signed(o_rdata) > $signed(x_r)) begin
          o_waddr = pos_r;
          o_wdata = o_rdata;
          if (pos_r == AW'(1)) begin
            state_nxt = S_INS0;
          end else begin
            pos_nxt = pos_r - AW'(1);
            o_raddr = pos_r - AW'(2);
          end
        end else begin
          o_waddr   = pos_r;
          o_wdata   = x_r;
          state_nxt = S_DONE;
        end
      end
      S_INS0: begin
        o_we      = 1'b1;
        o_waddr   = '0;
        o_wdata   = x_r;
        state_nxt = S_DONE;
      end
      S_MED1: begin
        if (total_r[0]) begin
          med_nxt   = o_rdata;
          neg_nxt   = sum_r[SUMW-1];
          q_nxt     = sum_r[SUMW-1] ? (~sum_r + SUMW'(1)) : sum_r;
          rem_nxt   = '0;
          cnt_nxt   = DCW'(SUMW);
          state_nxt = S_DIV;
        end else begin
          a_nxt     = o_rdata;
          o_raddr   = half[AW-1:0];
          state_nxt = S_MED2;
        end
      end
      S_MED2: begin
        med_nxt   = pair_sum[SB:1];
        neg_nxt   = sum_r[SUMW-1];
        q_nxt     = sum_r[SUMW-1] ? (~sum_r + SUMW'(1)) : sum_r;
        rem_nxt   = '0;
        cnt_nxt   = DCW'(SUMW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = qbit ? CW'(trial - {1'b0, total_r}) : trial[CW-1:0];
        q_nxt   = q_step;
        cnt_nxt = cnt_r - DCW'(1);
        if (cnt_r == DCW'(1)) begin
          mean_nxt  = q_fin[SB-1:0];
          flag_nxt  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RDW: begin
        if (diff[SB] != diff[SB-1]) begin
          cen_nxt = diff[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
          cen_nxt = diff[SB-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{PAD_O{1'b0}}, KW'(total_r), cen_r, mean_r, med_r};
          out_user_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      sum_r       <= '0;
      med_r       <= '0;
      mean_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      med_r       <= med_nxt;
      mean_r      <= mean_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    pos_r      <= pos_nxt;
    a_r        <= a_nxt;
    cen_r      <= cen_nxt;
    stat_r     <= stat_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- test/mmc_checker.sv -----
`timescale 1ns / 100ps
module mmc_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [47:0]              in_tdata,
  input  logic [2:0]               in_tuser,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [111:0]             out_tdata,
  input  logic [mmc_pkg::ST_W-1:0] out_tuser,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [31:0] median;
    logic signed [31:0] mean;
    logic signed [31:0] centered;
    logic [10:0]        kept;
    mmc_pkg::status_t   status;
  } mmc_result_t;

  mmc_result_t       expected_q[$];
  logic signed [31:0] arrival_mem[1024];
  logic signed [31:0] sorted_mem[1024];
  int                 kept_total;
  longint             sum_acc;
  logic signed [31:0] median_reg;
  logic signed [31:0] mean_reg;
  bit                 computed;

  assign pending = expected_q.size();

  function automatic mmc_result_t predict_result(mmc_pkg::cmd_t cmd, logic signed [31:0] x,
                                                 bit invalid, int idx);
    mmc_result_t r;
    int pos;
    int h;
    longint a;
    longint c;
    r = '0;
    r.status = mmc_pkg::ST_OK;
    case (cmd)
      mmc_pkg::CMD_LOAD: begin
        if (!invalid) begin
          if (kept_total >= 1024) begin
            r.status = mmc_pkg::ST_FULL;
          end else begin
            pos = kept_total;
            while (pos > 0 && sorted_mem[pos-1] > x) begin
              sorted_mem[pos] = sorted_mem[pos-1];
              pos--;
            end
            sorted_mem[pos] = x;
            arrival_mem[kept_total] = x;
            kept_total++;
            sum_acc += x;
            computed = 0;
            median_reg = 0;
            mean_reg = 0;
          end
        end
      end
      mmc_pkg::CMD_COMPUTE: begin
        if (kept_total == 0) begin
          r.status = mmc_pkg::ST_EMPTY;
        end else begin
          h = kept_total / 2;
          if (kept_total % 2 == 0) begin
            a = longint'(sorted_mem[h-1]) + longint'(sorted_mem[h]);
            median_reg = 32'((a >= 0) ? a / 2 : -((-a + 1) / 2));
          end else begin
            median_reg = sorted_mem[h];
          end
          mean_reg = 32'(sum_acc / kept_total);
          computed = 1;
        end
      end
      mmc_pkg::CMD_READ: begin
        if (!computed) begin
          r.status = mmc_pkg::ST_NOT_READY;
        end else if (idx >= kept_total) begin
          r.status = mmc_pkg::ST_BAD_INDEX;
        end else begin
          c = longint'(arrival_mem[idx]) - longint'(median_reg);
          if (c > 64'sd2147483647) c = 64'sd2147483647;
          if (c < -64'sd2147483648) c = -64'sd2147483648;
          r.centered = 32'(c);
        end
      end
      default: begin
        kept_total = 0;
        sum_acc = 0;
        median_reg = 0;
        mean_reg = 0;
        computed = 0;
      end
    endcase
    r.median = median_reg;
    r.mean = mean_reg;
    r.kept = 11'(kept_total);
    return r;
  endfunction

  always @(posedge clk) begin
    mmc_result_t e;
    if (!rst_n) begin
      expected_q.delete();
      kept_total = 0;
      sum_acc = 0;
      median_reg = 0;
      mean_reg = 0;
      computed = 0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[31:0] !== e.median) begin
            $error("median_value expected %0d actual %0d", e.median,
                   $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[63:32] !== e.mean) begin
            $error("mean_value expected %0d actual %0d", e.mean,
                   $signed(out_tdata[63:32]));
            fail_count++;
          end
          if (out_tdata[95:64] !== e.centered) begin
            $error("centered_value expected %0d actual %0d", e.centered,
                   $signed(out_tdata[95:64]));
            fail_count++;
          end
          if (out_tdata[106:96] !== e.kept) begin
            $error("kept_count expected %0d actual %0d", e.kept, out_tdata[106:96]);
            fail_count++;
          end
          if (out_tuser !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(),
                          predict_result(mmc_pkg::cmd_t'(in_tuser[1:0]), in_tdata[31:0],
                                         in_tuser[2], in_tdata[41:32]));
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [111:0] out_tdata;
  logic [2:0]   out_tuser;
  int           fail_count;
  int           pending;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  median_mean_centering uut (.*);

  mmc_checker chk (.*);

  task automatic send_item(mmc_pkg::cmd_t cmd, logic [31:0] x, bit inv, logic [9:0] idx);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, idx, x};
    in_tuser <= {inv, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 3);
      if (wait_cycles > 0) begin
        out_tready <= 0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int n;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
    send_item(mmc_pkg::CMD_READ, 0, 0, 0);
    send_item(mmc_pkg::CMD_LOAD, 32'h7fffffff, 0, 0);
    send_item(mmc_pkg::CMD_LOAD, 32'h80000000, 0, 0);
    send_item(mmc_pkg::CMD_LOAD, 32'h12345678, 1, 0);
    send_item(mmc_pkg::CMD_LOAD, 32'hffffffff, 0, 0);
    send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
    send_item(mmc_pkg::CMD_READ, 0, 0, 0);
    send_item(mmc_pkg::CMD_READ, 0, 0, 1);
    send_item(mmc_pkg::CMD_READ, 0, 0, 2);
    send_item(mmc_pkg::CMD_READ, 0, 0, 3);
    send_item(mmc_pkg::CMD_READ, 0, 0, 10'h3ff);
    send_item(mmc_pkg::CMD_LOAD, 32'h7fffffff, 0, 0);
    send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
    send_item(mmc_pkg::CMD_READ, 0, 0, 1);
    drain();
    send_item(mmc_pkg::CMD_CLEAR, 0, 0, 0);
    send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
    for (int i = 0; i < 300; i++)
      send_item(mmc_pkg::CMD_LOAD, $urandom_range(0, 7) - 3, 0, 0);
    send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
    send_item(mmc_pkg::CMD_READ, 0, 0, 10'h3ff);
    send_item(mmc_pkg::CMD_READ, 0, 0, 10'h080);
    send_item(mmc_pkg::CMD_CLEAR, 0, 0, 0);
    for (int s = 0; s < 30; s++) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_item(mmc_pkg::CMD_LOAD, rand_sample(), $urandom_range(0, 5) == 0, 0);
      send_item(mmc_pkg::CMD_COMPUTE, 0, 0, 0);
      for (int i = 0; i < 3; i++)
        send_item(mmc_pkg::CMD_READ, 0, 0, 10'($urandom_range(0, 13)));
      if ($urandom_range(0, 2) == 0)
        send_item(mmc_pkg::cmd_t'($urandom_range(0, 3)), $urandom, 1'($urandom),
                  10'($urandom));
      if ($urandom_range(0, 1) == 0) send_item(mmc_pkg::CMD_CLEAR, 0, 0, 0);
      if (s == 15) drain();
    end
    for (int i = 0; i < 20; i++)
      send_item(mmc_pkg::CMD_READ, 0, 0, 10'($urandom_range(0, 1023)));
    drain();
    if (fail_count == 0)
      $display("median_mean_centering verification clean");
    else
      $display("median_mean_centering verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("median_mean_centering verification failed");
    $finish;
  end

endmodule
